// ===== sv/swsfr_pkg.sv =====
// shared types and constants for the go-back-n sender with fast retransmit
package swsfr_pkg;

    localparam int SEQ_BITS     = 3;
    localparam int SEQ_SPACE    = 1 << SEQ_BITS;
    localparam int WINDOW       = 4;
    localparam int PAYLOAD_BITS = 64;

    typedef logic [SEQ_BITS-1:0]     seq_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [1:0]              func_t;
    typedef logic [1:0]              timer_t;
    typedef logic [1:0]              dup_t;
    typedef logic [1:0]              kind_t;

    localparam func_t FUNC_SEND    = 2'd0;
    localparam func_t FUNC_ACK     = 2'd1;
    localparam func_t FUNC_TIMEOUT = 2'd2;

    localparam timer_t TMR_NONE    = 2'd0;
    localparam timer_t TMR_START   = 2'd1;
    localparam timer_t TMR_STOP    = 2'd2;
    localparam timer_t TMR_RESTART = 2'd3;

    localparam dup_t DUP_LIMIT = 2'd3;

    // single: one result fully described by the command
    // send: store payload and transmit it
    // burst: retransmit cnt stored packets starting at seq
    localparam kind_t KIND_SINGLE = 2'd0;
    localparam kind_t KIND_SEND   = 2'd1;
    localparam kind_t KIND_BURST  = 2'd2;

    typedef struct packed {
        kind_t    kind;
        logic     accepted;
        timer_t   timer;
        seq_t     seq;
        seq_t     cnt;
        payload_t payload;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic empty;
        logic full;
        cmd_t cmd;
    } q_head_t;

endpackage

// ===== sv/sliding_window_sender_fast_retx_core.sv =====
// top level of the go-back-n sender with fast retransmit
//
//  channel   handshake         fields
//  -------   ---------------   ------------------------------------------------
//  item in   start / busy      func, payload, ack_num, ack_ok
//  result    done (strobe)     accepted, tx_valid, tx_seq, tx_payload,
//                              timer_action, last
//
// an item is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full
// send, ack, empty timeout and any other func give one beat, through the command queue and the registered outputs
// a fast retransmit or timeout gives one beat per packet, up to 4, one per
// cycle after a registered payload store read
// rst_n clears the window, ack state, queue and sequencer; the payload
// store is not cleared
// result beats are never held off by the receiver
module sliding_window_sender_fast_retx_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  swsfr_pkg::func_t    func,
    input  swsfr_pkg::payload_t payload,
    input  swsfr_pkg::seq_t     ack_num,
    input  logic                ack_ok,
    output logic                done,
    output logic                accepted,
    output logic                tx_valid,
    output swsfr_pkg::seq_t     tx_seq,
    output swsfr_pkg::payload_t tx_payload,
    output swsfr_pkg::timer_t   timer_action,
    output logic                last
);
    import swsfr_pkg::*;

    q_push_t q_push;
    q_head_t q_head;
    logic    pop;

    assign busy = q_head.full;

    swsfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .full    (q_head.full),
        .func    (func),
        .payload (payload),
        .ack_num (ack_num),
        .ack_ok  (ack_ok),
        .q_push  (q_push)
    );

    swsfr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .q_head (q_head)
    );

    swsfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .pop          (pop),
        .done         (done),
        .accepted     (accepted),
        .tx_valid     (tx_valid),
        .tx_seq       (tx_seq),
        .tx_payload   (tx_payload),
        .timer_action (timer_action),
        .last         (last)
    );

endmodule

// ===== sv/swsfr_front.sv =====
// front end: accepts items, keeps window and ack state, issues commands
module swsfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                full,
    input  swsfr_pkg::func_t    func,
    input  swsfr_pkg::payload_t payload,
    input  swsfr_pkg::seq_t     ack_num,
    input  logic                ack_ok,
    output swsfr_pkg::q_push_t  q_push
);
    import swsfr_pkg::*;

    seq_t base_reg, base_next;
    seq_t next_seq_reg, next_seq_next;
    dup_t dup_reg, dup_next;
    seq_t last_ack_reg, last_ack_next;
    logic last_ack_valid_reg, last_ack_valid_next;

    logic accept;
    seq_t limit;
    seq_t outstanding;
    dup_t dup_inc;
    cmd_t cmd;

    assign accept      = start && !full;
    assign limit       = base_reg + seq_t'(WINDOW);
    assign outstanding = next_seq_reg - base_reg;
    assign dup_inc     = dup_reg + 2'd1;

    always_comb
    begin
        base_next           = base_reg;
        next_seq_next       = next_seq_reg;
        dup_next            = dup_reg;
        last_ack_next       = last_ack_reg;
        last_ack_valid_next = last_ack_valid_reg;
        cmd.kind     = KIND_SINGLE;
        cmd.accepted = 1'b0;
        cmd.timer    = TMR_NONE;
        cmd.seq      = '0;
        cmd.cnt      = '0;
        cmd.payload  = '0;
        unique case (func)
            FUNC_SEND:
            begin
                if (next_seq_reg != limit)
                begin
                    cmd.kind      = KIND_SEND;
                    cmd.accepted  = 1'b1;
                    cmd.seq       = next_seq_reg;
                    cmd.payload   = payload;
                    cmd.timer     = (base_reg == next_seq_reg) ? TMR_START : TMR_NONE;
                    next_seq_next = next_seq_reg + seq_t'(1);
                end
            end
            FUNC_ACK:
            begin
                if (ack_ok)
                begin
                    base_next = ack_num;
                    if (ack_num == next_seq_reg)
                    begin
                        last_ack_next       = ack_num;
                        last_ack_valid_next = 1'b1;
                        dup_next            = '0;
                        cmd.timer           = TMR_STOP;
                    end
                    else if (last_ack_valid_reg && ack_num == last_ack_reg)
                    begin
                        cmd.timer = TMR_RESTART;
                        if (dup_inc == DUP_LIMIT)
                        begin
                            // third duplicate: resend the base packet
                            dup_next  = '0;
                            cmd.kind  = KIND_BURST;
                            cmd.seq   = ack_num;
                            cmd.cnt   = seq_t'(1);
                        end
                        else
                        begin
                            dup_next = dup_inc;
                        end
                    end
                    else
                    begin
                        last_ack_next       = ack_num;
                        last_ack_valid_next = 1'b1;
                        dup_next            = '0;
                        cmd.timer           = TMR_RESTART;
                    end
                end
            end
            FUNC_TIMEOUT:
            begin
                cmd.timer = TMR_RESTART;
                if (outstanding != '0)
                begin
                    cmd.kind = KIND_BURST;
                    cmd.seq  = base_reg;
                    cmd.cnt  = (outstanding > seq_t'(WINDOW)) ? seq_t'(WINDOW) : outstanding;
                end
            end
            default:
            begin
                cmd.kind = KIND_SINGLE;
            end
        endcase
    end

    assign q_push.push = accept;
    assign q_push.cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg           <= '0;
            next_seq_reg       <= '0;
            dup_reg            <= '0;
            last_ack_reg       <= '0;
            last_ack_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            base_reg           <= base_next;
            next_seq_reg       <= next_seq_next;
            dup_reg            <= dup_next;
            last_ack_reg       <= last_ack_next;
            last_ack_valid_reg <= last_ack_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !q_push.push)
        else $error("front pushed into a full queue");
    a_burst_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push.push && q_push.cmd.kind == KIND_BURST) |-> q_push.cmd.cnt != '0)
        else $error("burst command with zero count");
    a_dup_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        dup_reg != DUP_LIMIT)
        else $error("duplicate count reached limit without clearing");
`endif

endmodule

// ===== sv/swsfr_queue.sv =====
// two-entry command queue between front and back
module swsfr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  swsfr_pkg::q_push_t q_push,
    input  logic               pop,
    output swsfr_pkg::q_head_t q_head
);
    import swsfr_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign q_head.empty = (count_reg == 2'd0);
    assign q_head.full  = (count_reg == 2'd2);
    assign q_head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (q_push.push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !q_push.push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (q_push.push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_head.empty |-> !pop)
        else $error("pop from empty queue");
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_ptrs_track_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== sv/swsfr_back.sv =====
// back end: payload store and result sequencing
module swsfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  swsfr_pkg::q_head_t  q_head,
    output logic                pop,
    output logic                done,
    output logic                accepted,
    output logic                tx_valid,
    output swsfr_pkg::seq_t     tx_seq,
    output swsfr_pkg::payload_t tx_payload,
    output swsfr_pkg::timer_t   timer_action,
    output logic                last
);
    import swsfr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    payload_t mem [SEQ_SPACE];
    payload_t rd_data_reg;
    seq_t     rd_addr;

    logic state_reg, state_next;
    seq_t seq_reg, seq_next;
    seq_t left_reg, left_next;
    logic done_reg, done_next;

    logic     accepted_reg, accepted_next;
    logic     tx_valid_reg, tx_valid_next;
    seq_t     tx_seq_reg, tx_seq_next;
    payload_t tx_payload_reg, tx_payload_next;
    timer_t   timer_reg, timer_next;
    logic     last_reg, last_next;

    assign pop = (state_reg == ST_IDLE) && !q_head.empty;

    always_comb
    begin
        state_next      = state_reg;
        seq_next        = seq_reg;
        left_next       = left_reg;
        done_next       = 1'b0;
        accepted_next   = accepted_reg;
        tx_valid_next   = tx_valid_reg;
        tx_seq_next     = tx_seq_reg;
        tx_payload_next = tx_payload_reg;
        timer_next      = timer_reg;
        last_next       = last_reg;
        rd_addr         = q_head.cmd.seq;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (q_head.cmd.kind == KIND_BURST)
                    begin
                        // store read issued now, data lands next cycle
                        seq_next   = q_head.cmd.seq;
                        left_next  = q_head.cmd.cnt;
                        timer_next = q_head.cmd.timer;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        accepted_next   = q_head.cmd.accepted;
                        tx_valid_next   = (q_head.cmd.kind == KIND_SEND);
                        tx_seq_next     = q_head.cmd.seq;
                        tx_payload_next = q_head.cmd.payload;
                        timer_next      = q_head.cmd.timer;
                        last_next       = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                rd_addr         = seq_reg + seq_t'(1);
                done_next       = 1'b1;
                accepted_next   = 1'b0;
                tx_valid_next   = 1'b1;
                tx_seq_next     = seq_reg;
                tx_payload_next = rd_data_reg;
                if (left_reg == seq_t'(1))
                begin
                    timer_next = TMR_RESTART;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    timer_next = TMR_NONE;
                    last_next  = 1'b0;
                    seq_next   = seq_reg + seq_t'(1);
                    left_next  = left_reg - seq_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_head.cmd.kind == KIND_SEND)
        begin
            mem[q_head.cmd.seq] <= q_head.cmd.payload;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        accepted_reg   <= accepted_next;
        tx_valid_reg   <= tx_valid_next;
        tx_seq_reg     <= tx_seq_next;
        tx_payload_reg <= tx_payload_next;
        timer_reg      <= timer_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= '0;
            left_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
        end
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_seq       = tx_seq_reg;
    assign tx_payload   = tx_payload_reg;
    assign timer_action = timer_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> left_reg != '0)
        else $error("emitting with no packets left");
    a_accept_means_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && accepted_reg) |-> tx_valid_reg)
        else $error("accepted send without transmission");
    a_idle_beat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !tx_valid_reg) |-> last_reg)
        else $error("non-transmit beat not marked last");
    a_no_pop_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !pop)
        else $error("queue popped during burst");
`endif

endmodule

// ===== sim/tb.sv =====
// testbench for the go-back-n sender core: scoreboard class and top module
package swsfr_tb_pkg;
    import swsfr_pkg::*;

    // func code that the block must answer with an empty beat
    localparam func_t FUNC_UNKNOWN = 2'd3;

    typedef struct packed {
        logic     accepted;
        logic     tx_valid;
        seq_t     tx_seq;
        payload_t tx_payload;
        timer_t   timer_action;
        logic     last;
    } beat_t;

    class retx_scoreboard;
        seq_t     base_seq;
        seq_t     next_seq;
        dup_t     dup_cnt;
        seq_t     last_ack;
        logic     ack_seen;
        payload_t stored [SEQ_SPACE];
        beat_t    expected [$];
        int       errors;

        function new();
            base_seq = '0;
            next_seq = '0;
            dup_cnt  = '0;
            last_ack = '0;
            ack_seen = 1'b0;
            errors   = 0;
            foreach (stored[i])
                stored[i] = '0;
        endfunction

        function seq_t in_flight();
            in_flight = next_seq - base_seq;
        endfunction

        function void push(logic acc, logic txv, seq_t s, payload_t p, timer_t t,
                           logic lst);
            beat_t b;
            b.accepted     = acc;
            b.tx_valid     = txv;
            b.tx_seq       = s;
            b.tx_payload   = p;
            b.timer_action = t;
            b.last         = lst;
            expected.push_back(b);
        endfunction

        // works out the beats caused by one accepted item
        function void take_item(func_t f, payload_t p, seq_t a, logic ok);
            seq_t lim;
            seq_t n;
            seq_t s;
            int   i;
            case (f)
                FUNC_SEND:
                begin
                    lim = base_seq + seq_t'(WINDOW);
                    if (next_seq == lim)
                        push(1'b0, 1'b0, '0, '0, TMR_NONE, 1'b1);
                    else
                    begin
                        stored[next_seq] = p;
                        push(1'b1, 1'b1, next_seq, p,
                             (base_seq == next_seq) ? TMR_START : TMR_NONE, 1'b1);
                        next_seq = next_seq + 1'b1;
                    end
                end
                FUNC_ACK:
                begin
                    if (!ok)
                        push(1'b0, 1'b0, '0, '0, TMR_NONE, 1'b1);
                    else
                    begin
                        base_seq = a;
                        if (base_seq == next_seq)
                        begin
                            last_ack = base_seq;
                            ack_seen = 1'b1;
                            dup_cnt  = '0;
                            push(1'b0, 1'b0, '0, '0, TMR_STOP, 1'b1);
                        end
                        else if (ack_seen && base_seq == last_ack)
                        begin
                            dup_cnt = dup_cnt + 1'b1;
                            // third duplicate: fast retransmit of the base packet
                            if (dup_cnt == DUP_LIMIT)
                            begin
                                dup_cnt = '0;
                                push(1'b0, 1'b1, base_seq, stored[base_seq], TMR_RESTART,
                                     1'b1);
                            end
                            else
                                push(1'b0, 1'b0, '0, '0, TMR_RESTART, 1'b1);
                        end
                        else
                        begin
                            last_ack = base_seq;
                            ack_seen = 1'b1;
                            dup_cnt  = '0;
                            push(1'b0, 1'b0, '0, '0, TMR_RESTART, 1'b1);
                        end
                    end
                end
                FUNC_TIMEOUT:
                begin
                    n = in_flight();
                    if (n == 0)
                        push(1'b0, 1'b0, '0, '0, TMR_RESTART, 1'b1);
                    else
                    begin
                        // an out-of-window ack can leave more than a window outstanding
                        if (n > WINDOW)
                            n = seq_t'(WINDOW);
                        for (i = 0; i < n; i++)
                        begin
                            s = base_seq + seq_t'(i);
                            push(1'b0, 1'b1, s, stored[s],
                                 (i == n - 1) ? TMR_RESTART : TMR_NONE, i == n - 1);
                        end
                    end
                end
                default:
                    push(1'b0, 1'b0, '0, '0, TMR_NONE, 1'b1);
            endcase
        endfunction

        function string show(beat_t b);
            return $sformatf("acc=%0b tx=%0b seq=%0d pl=%h tmr=%0d last=%0b",
                             b.accepted, b.tx_valid, b.tx_seq, b.tx_payload,
                             b.timer_action, b.last);
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            if (expected.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: %s", show(got));
            end
            else
            begin
                want = expected.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("beat mismatch: expected %s, got %s", show(want),
                                 show(got));
                end
            end
        endfunction
    endclass

endpackage

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swsfr_pkg::*;
    import swsfr_tb_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    func_t    func;
    payload_t payload;
    seq_t     ack_num;
    logic     ack_ok;
    logic     done;
    logic     accepted;
    logic     tx_valid;
    seq_t     tx_seq;
    payload_t tx_payload;
    timer_t   timer_action;
    logic     last;

    retx_scoreboard sb;
    logic           no_gaps;

    sliding_window_sender_fast_retx_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .payload      (payload),
        .ack_num      (ack_num),
        .ack_ok       (ack_ok),
        .done         (done),
        .accepted     (accepted),
        .tx_valid     (tx_valid),
        .tx_seq       (tx_seq),
        .tx_payload   (tx_payload),
        .timer_action (timer_action),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.take_item(func, payload, ack_num, ack_ok);
            if (done)
                sb.check_beat({accepted, tx_valid, tx_seq, tx_payload, timer_action, last});
        end
    end

    // drives one item and returns at the edge that takes it
    task automatic issue_item(input func_t f, input payload_t p, input seq_t a,
                              input logic ok);
        int gap;
        gap = 0;
        // each cycle idles with a chance of 18 in 100
        while (!no_gaps && gap < 8 && $urandom_range(99) < 18)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        func    <= f;
        payload <= p;
        ack_num <= a;
        ack_ok  <= ok;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // acks most often, many near the window or duplicates, so fast retransmit gets hit
    task automatic pick_item(output func_t f, output payload_t p, output seq_t a,
                             output logic ok);
        int   r;
        seq_t span;
        r  = $urandom_range(99);
        p  = {$urandom, $urandom};
        a  = seq_t'($urandom_range(7));
        ok = 1'($urandom_range(1));
        if ($urandom_range(99) < 5)
            p = '0;
        else if ($urandom_range(99) < 5)
            p = '1;
        if (r < 36)
            f = FUNC_SEND;
        else if (r < 82)
        begin
            f    = FUNC_ACK;
            ok   = ($urandom_range(99) < 88);
            span = sb.in_flight();
            r    = $urandom_range(99);
            if (r < 45 && sb.ack_seen)
                a = sb.last_ack;
            else if (r < 88)
                a = sb.base_seq + seq_t'($urandom_range(span));
        end
        else if (r < 97)
            f = FUNC_TIMEOUT;
        else
            f = FUNC_UNKNOWN;
    endtask

    initial
    begin
        func_t    f;
        payload_t p;
        seq_t     a;
        logic     ok;
        int       waited;

        sb      = new();
        no_gaps = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        func    = FUNC_SEND;
        payload = '0;
        ack_num = '0;
        ack_ok  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part; it also writes every store entry before the random part
        issue_item(FUNC_TIMEOUT, '0, 3'd0, 1'b0);
        issue_item(FUNC_ACK, '1, 3'd7, 1'b0);
        issue_item(FUNC_UNKNOWN, '1, 3'd7, 1'b1);
        issue_item(FUNC_SEND, '0, 3'd0, 1'b0);
        issue_item(FUNC_SEND, '1, 3'd7, 1'b1);
        issue_item(FUNC_SEND, 64'hA5A5_5A5A_F0F0_0F0F, 3'd0, 1'b1);
        issue_item(FUNC_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0);
        issue_item(FUNC_SEND, 64'hDEAD_BEEF_CAFE_F00D, 3'd0, 1'b0);
        issue_item(FUNC_TIMEOUT, '0, 3'd0, 1'b0);
        issue_item(FUNC_ACK, '0, 3'd1, 1'b1);
        issue_item(FUNC_ACK, '0, 3'd1, 1'b1);
        issue_item(FUNC_ACK, '0, 3'd1, 1'b1);
        issue_item(FUNC_ACK, '0, 3'd1, 1'b1);
        issue_item(FUNC_ACK, '0, 3'd4, 1'b1);
        issue_item(FUNC_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0);
        issue_item(FUNC_SEND, 64'h5555_5555_5555_5555, 3'd0, 1'b0);
        issue_item(FUNC_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 1'b0);
        issue_item(FUNC_SEND, 64'h7FFF_FFFF_FFFF_FFFE, 3'd0, 1'b0);
        // ack behind the base leaves six outstanding, timeout caps at a window
        issue_item(FUNC_ACK, '0, 3'd2, 1'b1);
        issue_item(FUNC_TIMEOUT, '0, 3'd0, 1'b0);
        issue_item(FUNC_ACK, '0, 3'd0, 1'b1);
        issue_item(FUNC_ACK, '0, 3'd0, 1'b1);

        for (int i = 0; i < 320; i++)
        begin
            no_gaps = (i >= 120 && i < 200);
            pick_item(f, p, a, ok);
            issue_item(f, p, a, ok);
        end
        @(negedge clk);
        start <= 1'b0;

        waited = 0;
        while (sb.expected.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
sv/swsfr_pkg.sv
sv/swsfr_front.sv
sv/swsfr_queue.sv
sv/swsfr_back.sv
sv/sliding_window_sender_fast_retx_core.sv
sim/tb.sv
